>>> rtl/rcb_pkg.sv
// Package for the request circuit breaker: item structs, mode and item-kind
// codes, register indexes, reset values and saturating helpers.
// Depends on nothing; every other rtl file imports it.
package rcb_pkg;

  typedef enum logic [1:0] {
    MODE_CLOSED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_HALF   = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REQ_CALL       = 3'd0,
    REQ_DONE       = 3'd1,
    REQ_TICK       = 3'd2,
    REQ_FORCE_OPEN = 3'd3,
    REQ_FORCE_HALF = 3'd4,
    REQ_RESET      = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    REG_FAILURE_LIMIT  = 2'd0,
    REG_CLOSE_LIMIT    = 2'd1,
    REG_OPEN_TIMEOUT   = 2'd2,
    REG_HALF_CALL_LIM  = 2'd3
  } reg_e;

  localparam int unsigned AddrWidth = 4;

  localparam logic [15:0] FailureLimitRst = 16'd5;
  localparam logic [15:0] CloseLimitRst   = 16'd3;
  localparam logic [23:0] OpenTimeoutRst  = 24'd30000;
  localparam logic [7:0]  HalfCallLimRst  = 8'd1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic        outcome_ok;
    logic [15:0] response_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        admitted;
    logic [31:0] total_count;
    logic [31:0] success_count;
    logic [31:0] failure_count;
    logic [31:0] rejected_count;
    logic [15:0] failure_streak;
    logic [15:0] min_response;
    logic [15:0] max_response;
    logic [47:0] response_sum;
    logic [31:0] ms_in_mode;
  } out_item_t;

  typedef struct packed {
    logic [15:0] failure_limit;
    logic [15:0] close_success_limit;
    logic [23:0] open_timeout_ms;
    logic [7:0]  half_open_call_limit;
  } cfg_t;

  function automatic logic [31:0] sat_inc32(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [15:0] sat_inc16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

>>> rtl/rcb_cfg.sv
// Configuration registers behind the APB-style write/read port.
// Depends on rcb_pkg for the register indexes, reset values and cfg_t.
module rcb_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rcb_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output rcb_pkg::cfg_t                 cfg_o
);
  import rcb_pkg::*;

  cfg_t  cfg_q, cfg_d;
  reg_e  idx;
  logic  wr_en;

  assign idx    = reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_FAILURE_LIMIT: cfg_d.failure_limit        = pwdata[15:0];
        REG_CLOSE_LIMIT:   cfg_d.close_success_limit  = pwdata[15:0];
        REG_OPEN_TIMEOUT:  cfg_d.open_timeout_ms      = pwdata[23:0];
        REG_HALF_CALL_LIM: cfg_d.half_open_call_limit = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FAILURE_LIMIT: prdata = {16'd0, cfg_q.failure_limit};
      REG_CLOSE_LIMIT:   prdata = {16'd0, cfg_q.close_success_limit};
      REG_OPEN_TIMEOUT:  prdata = {8'd0, cfg_q.open_timeout_ms};
      REG_HALF_CALL_LIM: prdata = {24'd0, cfg_q.half_open_call_limit};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.failure_limit        <= FailureLimitRst;
      cfg_q.close_success_limit  <= CloseLimitRst;
      cfg_q.open_timeout_ms      <= OpenTimeoutRst;
      cfg_q.half_open_call_limit <= HalfCallLimRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/rcb_core.sv
// Input register and breaker state: decodes one item per cycle while the result
// register accepts, updates mode, counters and response statistics, and emits the result item.
// Depends on rcb_pkg.
module rcb_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rcb_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rcb_pkg::in_item_t  in_item_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output rcb_pkg::out_item_t res_item_o
);
  import rcb_pkg::*;

  logic     s1_valid_q;
  in_item_t s1_item_q;
  logic     advance;

  mode_e       mode_q, mode_d;
  logic [15:0] streak_q, streak_d;
  logic [31:0] timer_q, timer_d;
  logic [7:0]  infl_q, infl_d;
  logic [15:0] probe_q, probe_d;
  logic [31:0] adm_q, adm_d;
  logic [31:0] ok_q, ok_d;
  logic [31:0] fail_q, fail_d;
  logic [31:0] rej_q, rej_d;
  logic [15:0] rt_min_q, rt_min_d;
  logic [15:0] rt_max_q, rt_max_d;
  logic [47:0] rt_sum_q, rt_sum_d;
  logic        seen_q, seen_d;
  logic        admitted;
  logic        timeout_hit;
  logic [48:0] sum_wide;
  req_e        kind;

  assign advance     = s1_valid_q && res_ready_i;
  assign in_ready_o  = !s1_valid_q || advance;
  assign res_valid_o = s1_valid_q;
  assign kind        = req_e'(s1_item_q.req_type);
  assign timeout_hit = timer_q >= {8'd0, cfg_i.open_timeout_ms};
  assign sum_wide    = {1'b0, rt_sum_q} + {33'd0, s1_item_q.response_ms};

  always_comb begin
    mode_d   = mode_q;
    streak_d = streak_q;
    timer_d  = timer_q;
    infl_d   = infl_q;
    probe_d  = probe_q;
    adm_d    = adm_q;
    ok_d     = ok_q;
    fail_d   = fail_q;
    rej_d    = rej_q;
    rt_min_d = rt_min_q;
    rt_max_d = rt_max_q;
    rt_sum_d = rt_sum_q;
    seen_d   = seen_q;
    admitted = 1'b0;
    unique case (kind)
      REQ_CALL: begin
        if (mode_q == MODE_OPEN && timeout_hit) begin
          mode_d  = MODE_HALF;
          timer_d = 32'd0;
          infl_d  = 8'd0;
          probe_d = 16'd0;
        end
        if (mode_q == MODE_OPEN && !timeout_hit) begin
          rej_d = sat_inc32(rej_q);
        end else if (mode_d == MODE_HALF && infl_d >= cfg_i.half_open_call_limit) begin
          rej_d = sat_inc32(rej_q);
        end else begin
          if (mode_d == MODE_HALF && infl_d != 8'hFF) begin
            infl_d = infl_d + 8'd1;
          end
          adm_d    = sat_inc32(adm_q);
          admitted = 1'b1;
        end
      end
      REQ_DONE: begin
        seen_d = 1'b1;
        if (!seen_q) begin
          rt_min_d = s1_item_q.response_ms;
          rt_max_d = s1_item_q.response_ms;
        end else begin
          if (s1_item_q.response_ms < rt_min_q) rt_min_d = s1_item_q.response_ms;
          if (s1_item_q.response_ms > rt_max_q) rt_max_d = s1_item_q.response_ms;
        end
        rt_sum_d = sum_wide[48] ? 48'hFFFF_FFFF_FFFF : sum_wide[47:0];
        if (s1_item_q.outcome_ok) begin
          ok_d     = sat_inc32(ok_q);
          streak_d = 16'd0;
          if (mode_q == MODE_HALF) begin
            probe_d = sat_inc16(probe_q);
            if (probe_d >= cfg_i.close_success_limit) begin
              mode_d  = MODE_CLOSED;
              timer_d = 32'd0;
            end
          end
        end else begin
          fail_d   = sat_inc32(fail_q);
          streak_d = sat_inc16(streak_q);
          if (mode_q != MODE_OPEN && streak_d >= cfg_i.failure_limit) begin
            mode_d  = MODE_OPEN;
            timer_d = 32'd0;
          end
        end
        if (mode_d == MODE_HALF && mode_q == MODE_HALF && infl_q != 8'd0) begin
          infl_d = infl_q - 8'd1;
        end
      end
      REQ_TICK: timer_d = sat_inc32(timer_q);
      REQ_FORCE_OPEN: begin
        mode_d  = MODE_OPEN;
        timer_d = 32'd0;
      end
      REQ_FORCE_HALF: begin
        mode_d  = MODE_HALF;
        timer_d = 32'd0;
        infl_d  = 8'd0;
        probe_d = 16'd0;
      end
      REQ_RESET: begin
        mode_d   = MODE_CLOSED;
        timer_d  = 32'd0;
        streak_d = 16'd0;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_item_o.mode           = mode_d;
    res_item_o.admitted       = admitted;
    res_item_o.total_count    = adm_d;
    res_item_o.success_count  = ok_d;
    res_item_o.failure_count  = fail_d;
    res_item_o.rejected_count = rej_d;
    res_item_o.failure_streak = streak_d;
    res_item_o.min_response   = rt_min_d;
    res_item_o.max_response   = rt_max_d;
    res_item_o.response_sum   = rt_sum_d;
    res_item_o.ms_in_mode     = timer_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      mode_q     <= MODE_CLOSED;
      streak_q   <= 16'd0;
      timer_q    <= 32'd0;
      infl_q     <= 8'd0;
      probe_q    <= 16'd0;
      adm_q      <= 32'd0;
      ok_q       <= 32'd0;
      fail_q     <= 32'd0;
      rej_q      <= 32'd0;
      rt_min_q   <= 16'd0;
      rt_max_q   <= 16'd0;
      rt_sum_q   <= 48'd0;
      seen_q     <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        mode_q   <= mode_d;
        streak_q <= streak_d;
        timer_q  <= timer_d;
        infl_q   <= infl_d;
        probe_q  <= probe_d;
        adm_q    <= adm_d;
        ok_q     <= ok_d;
        fail_q   <= fail_d;
        rej_q    <= rej_d;
        rt_min_q <= rt_min_d;
        rt_max_q <= rt_max_d;
        rt_sum_q <= rt_sum_d;
        seen_q   <= seen_d;
      end
    end
  end

endmodule

>>> rtl/rcb_out.sv
// Result register: holds one finished result item until the consumer takes it.
// Depends on rcb_pkg for out_item_t.
module rcb_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  output logic               res_ready_o,
  input  rcb_pkg::out_item_t res_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rcb_pkg::out_item_t out_item_o
);
  import rcb_pkg::*;

  logic      valid_q;
  out_item_t item_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      item_q <= res_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

endmodule

>>> rtl/request_circuit_breaker.sv
// Top level of the request circuit breaker: config port, state core, result register.
// Depends on rcb_pkg, rcb_cfg, rcb_core and rcb_out.
//
//   channel   signals                            direction
//   in        in_valid_i / in_ready_o / in_item_i   item in
//   out       out_valid_o / out_ready_i / out_item_o result out
//   cfg       psel penable pwrite paddr pwdata / prdata pready
//
// One item per cycle sustained while out_ready_i is high; an accepted item passes the
// input register, then the state update into the result register.
// Reset returns the limits to their defaults and the breaker to closed, all
// counters zero. While a result waits with out_ready_i low, one more item is taken
// into the input register, then in_ready_o drops until the result is taken.
module request_circuit_breaker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rcb_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rcb_pkg::out_item_t            out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rcb_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import rcb_pkg::*;

  cfg_t      cfg;
  logic      res_valid;
  logic      res_ready;
  out_item_t res_item;

  rcb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rcb_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_item_o  (res_item)
  );

  rcb_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_item_i  (res_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while result register can move");

  a_admit_not_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.admitted) |-> (out_item_o.mode != MODE_OPEN))
    else $error("item admitted while open");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.min_response <= out_item_o.max_response))
    else $error("min response above max response");

endmodule

>>> bench/tb_request_circuit_breaker.sv
// Testbench for request_circuit_breaker: directed and random item streams, APB limit setup,
// an item-level status predictor and an in-order checker on the result channel.
// Depends on rcb_pkg and the request_circuit_breaker rtl.
`timescale 1ns / 1ps

module tb_request_circuit_breaker;
  import rcb_pkg::*;

  localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
  localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_item_t             in_item_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_item_t            out_item_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  request_circuit_breaker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  cfg_t limits = '{FailureLimitRst, CloseLimitRst, OpenTimeoutRst, HalfCallLimRst};

  mode_e       brk_mode = MODE_CLOSED;
  logic [15:0] fail_run = '0;
  logic [31:0] mode_ms = '0;
  logic [7:0]  probes_out = '0;
  logic [15:0] probe_ok = '0;
  logic [31:0] adm_cnt = '0;
  logic [31:0] ok_cnt = '0;
  logic [31:0] fail_cnt = '0;
  logic [31:0] rej_cnt = '0;
  logic [15:0] rt_lo = '0;
  logic [15:0] rt_hi = '0;
  logic [47:0] rt_total = '0;
  logic        have_sample = 1'b0;

  out_item_t status_due[$];
  int        fails = 0;
  bit        sender_idles = 1'b1;
  bit        receiver_idles = 1'b1;
  int        hold_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] bump32(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic in_item_t item_of(logic [2:0] kind, logic ok, logic [15:0] rt);
    in_item_t it;
    it.req_type    = kind;
    it.outcome_ok  = ok;
    it.response_ms = rt;
    return it;
  endfunction

  function automatic in_item_t random_item(int fail_pct);
    int          pick;
    logic [2:0]  kind;
    logic [15:0] rt;
    pick = $urandom_range(0, 99);
    if (pick < 35) kind = REQ_CALL;
    else if (pick < 65) kind = REQ_DONE;
    else if (pick < 88) kind = REQ_TICK;
    else if (pick < 91) kind = REQ_FORCE_OPEN;
    else if (pick < 94) kind = REQ_FORCE_HALF;
    else if (pick < 97) kind = REQ_RESET;
    else kind = $urandom_range(0, 1) ? REQ_UNUSED_LO : REQ_UNUSED_HI;
    case ($urandom_range(0, 9))
      0: rt = 16'($urandom);
      1: rt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: rt = 16'($urandom_range(0, 2000));
    endcase
    return item_of(kind, $urandom_range(0, 99) >= fail_pct, rt);
  endfunction

  task automatic switch_mode(input mode_e m);
    brk_mode = m;
    mode_ms  = '0;
    if (m == MODE_HALF) begin
      probes_out = '0;
      probe_ok   = '0;
    end
  endtask

  task automatic update_breaker(input in_item_t it, output out_item_t res);
    logic [48:0] sum;
    logic        granted;
    mode_e       prior;
    granted = 1'b0;
    prior   = brk_mode;
    case (it.req_type)
      REQ_CALL: begin
        if (brk_mode == MODE_OPEN && mode_ms >= {8'd0, limits.open_timeout_ms}) begin
          switch_mode(MODE_HALF);
        end
        if (brk_mode == MODE_OPEN) begin
          rej_cnt = bump32(rej_cnt);
        end else if (brk_mode == MODE_HALF && probes_out >= limits.half_open_call_limit) begin
          rej_cnt = bump32(rej_cnt);
        end else begin
          if (brk_mode == MODE_HALF && probes_out != 8'hFF) probes_out = probes_out + 8'd1;
          adm_cnt = bump32(adm_cnt);
          granted = 1'b1;
        end
      end
      REQ_DONE: begin
        if (!have_sample) begin
          rt_lo       = it.response_ms;
          rt_hi       = it.response_ms;
          have_sample = 1'b1;
        end else begin
          if (it.response_ms < rt_lo) rt_lo = it.response_ms;
          if (it.response_ms > rt_hi) rt_hi = it.response_ms;
        end
        sum      = {1'b0, rt_total} + {33'd0, it.response_ms};
        rt_total = sum[48] ? SUM_MAX : sum[47:0];
        if (it.outcome_ok) begin
          ok_cnt   = bump32(ok_cnt);
          fail_run = '0;
          if (brk_mode == MODE_HALF) begin
            if (probe_ok != 16'hFFFF) probe_ok = probe_ok + 16'd1;
            if (probe_ok >= limits.close_success_limit) switch_mode(MODE_CLOSED);
          end
        end else begin
          fail_cnt = bump32(fail_cnt);
          if (fail_run != 16'hFFFF) fail_run = fail_run + 16'd1;
          if ((brk_mode == MODE_CLOSED || brk_mode == MODE_HALF) &&
              fail_run >= limits.failure_limit) begin
            switch_mode(MODE_OPEN);
          end
        end
        if (brk_mode == MODE_HALF && prior == MODE_HALF && probes_out != 8'd0) begin
          probes_out = probes_out - 8'd1;
        end
      end
      REQ_TICK:       mode_ms = bump32(mode_ms);
      REQ_FORCE_OPEN: switch_mode(MODE_OPEN);
      REQ_FORCE_HALF: switch_mode(MODE_HALF);
      REQ_RESET: begin
        fail_run = '0;
        switch_mode(MODE_CLOSED);
      end
      default: ;
    endcase
    res.mode           = brk_mode;
    res.admitted       = granted;
    res.total_count    = adm_cnt;
    res.success_count  = ok_cnt;
    res.failure_count  = fail_cnt;
    res.rejected_count = rej_cnt;
    res.failure_streak = fail_run;
    res.min_response   = rt_lo;
    res.max_response   = rt_hi;
    res.response_sum   = rt_total;
    res.ms_in_mode     = mode_ms;
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_due.size() == 0) begin
        $display("%0t: unexpected item expected none actual %0h", $time, out_item_o);
        fails++;
      end else begin
        want = status_due.pop_front();
        check_field("mode", 64'(want.mode), 64'(out_item_o.mode));
        check_field("admitted", 64'(want.admitted), 64'(out_item_o.admitted));
        check_field("total_count", 64'(want.total_count), 64'(out_item_o.total_count));
        check_field("success_count", 64'(want.success_count),
                    64'(out_item_o.success_count));
        check_field("failure_count", 64'(want.failure_count),
                    64'(out_item_o.failure_count));
        check_field("rejected_count", 64'(want.rejected_count),
                    64'(out_item_o.rejected_count));
        check_field("failure_streak", 64'(want.failure_streak),
                    64'(out_item_o.failure_streak));
        check_field("min_response", 64'(want.min_response), 64'(out_item_o.min_response));
        check_field("max_response", 64'(want.max_response), 64'(out_item_o.max_response));
        check_field("response_sum", 64'(want.response_sum), 64'(out_item_o.response_sum));
        check_field("ms_in_mode", 64'(want.ms_in_mode), 64'(out_item_o.ms_in_mode));
      end
    end
  end

  initial begin : result_ready
    int gap_left;
    gap_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else if (gap_left > 0) begin
        out_ready_i <= 1'b0;
        gap_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (receiver_idles && $urandom_range(0, 99) < 25) gap_left = pick_gap();
      end
    end
  end

  task automatic send_item(input in_item_t it);
    int        gap;
    out_item_t res;
    gap = sender_idles ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    update_breaker(it, res);
    status_due.push_back(res);
  endtask

  task automatic settle_breaker();
    in_valid_i <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic program_limit(input reg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_FAILURE_LIMIT: limits.failure_limit        = val[15:0];
      REG_CLOSE_LIMIT:   limits.close_success_limit  = val[15:0];
      REG_OPEN_TIMEOUT:  limits.open_timeout_ms      = val[23:0];
      default:           limits.half_open_call_limit = val[7:0];
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== val) begin
      $display("%0t: register %0d expected %0h actual %0h", $time, idx, val, prdata);
      fails++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_all(input logic [15:0] fl, input logic [15:0] cl,
                             input logic [23:0] tmo, input logic [7:0] calls);
    settle_breaker();
    program_limit(REG_FAILURE_LIMIT, {16'd0, fl});
    program_limit(REG_CLOSE_LIMIT, {16'd0, cl});
    program_limit(REG_OPEN_TIMEOUT, {8'd0, tmo});
    program_limit(REG_HALF_CALL_LIM, {24'd0, calls});
  endtask

  task automatic test_samples_and_spare_kinds();
    send_item(item_of(REQ_UNUSED_LO, 1'b1, 16'hFFFF));
    send_item(item_of(REQ_UNUSED_HI, 1'b0, 16'h0000));
    send_item(item_of(REQ_CALL, 1'b1, 16'hFFFF));
    send_item(item_of(REQ_DONE, 1'b1, 16'd1234));
    send_item(item_of(REQ_DONE, 1'b0, 16'hFFFF));
    send_item(item_of(REQ_DONE, 1'b1, 16'h0000));
    send_item(item_of(REQ_TICK, 1'b0, 16'h0000));
  endtask

  task automatic test_trip_and_probe();
    program_all(16'd1, 16'd1, 24'd0, 8'd1);
    send_item(item_of(REQ_DONE, 1'b0, 16'd10));
    send_item(item_of(REQ_DONE, 1'b1, 16'd20));
    send_item(item_of(REQ_CALL, 1'b0, 16'd0));
    send_item(item_of(REQ_CALL, 1'b0, 16'd0));
    send_item(item_of(REQ_DONE, 1'b0, 16'd30));
    send_item(item_of(REQ_CALL, 1'b0, 16'd0));
    send_item(item_of(REQ_DONE, 1'b1, 16'd40));
    send_item(item_of(REQ_FORCE_HALF, 1'b0, 16'd0));
    send_item(item_of(REQ_FORCE_OPEN, 1'b0, 16'd0));
    send_item(item_of(REQ_RESET, 1'b0, 16'd0));
  endtask

  task automatic test_zero_limits();
    program_all(16'd0, 16'd0, 24'd0, 8'd0);
    send_item(item_of(REQ_FORCE_HALF, 1'b0, 16'd0));
    send_item(item_of(REQ_CALL, 1'b0, 16'd0));
    send_item(item_of(REQ_DONE, 1'b1, 16'd5));
    send_item(item_of(REQ_DONE, 1'b0, 16'd6));
  endtask

  task automatic test_wide_limits();
    program_all(16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 8'hFF);
    send_item(item_of(REQ_FORCE_OPEN, 1'b0, 16'd0));
    send_item(item_of(REQ_TICK, 1'b0, 16'd0));
    send_item(item_of(REQ_CALL, 1'b0, 16'd0));
    send_item(item_of(REQ_FORCE_HALF, 1'b0, 16'd0));
    send_item(item_of(REQ_CALL, 1'b0, 16'd0));
    send_item(item_of(REQ_CALL, 1'b0, 16'd0));
  endtask

  task automatic test_random_traffic();
    int          fail_pct;
    logic [15:0] fl;
    logic [15:0] cl;
    logic [23:0] tmo;
    logic [7:0]  calls;
    for (int phase = 0; phase < 6; phase++) begin
      fl    = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(1, 6));
      cl    = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(1, 4));
      tmo   = ($urandom_range(0, 9) == 0) ? 24'hFF_FFFF : 24'($urandom_range(0, 12));
      calls = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(1, 4));
      if (phase == 0) begin
        fl  = 16'd2;
        cl  = 16'd2;
        tmo = 24'd3;
      end
      program_all(fl, cl, tmo, calls);
      sender_idles   = (phase != 1);
      receiver_idles = (phase != 1);
      fail_pct       = $urandom_range(10, 70);
      repeat (240) send_item(random_item(fail_pct));
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  task automatic test_long_stall();
    program_all(16'd3, 16'd2, 24'd4, 8'd2);
    sender_idles = 1'b0;
    hold_cycles  = 300;
    repeat (60) send_item(random_item(40));
    sender_idles = 1'b1;
  endtask

  initial begin
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    rst_ni     <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_samples_and_spare_kinds();
    test_trip_and_probe();
    test_zero_limits();
    test_wide_limits();
    test_random_traffic();
    test_long_stall();
    settle_breaker();
    repeat (10) @(posedge clk_i);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rcb_pkg.sv
rtl/rcb_cfg.sv
rtl/rcb_core.sv
rtl/rcb_out.sv
rtl/request_circuit_breaker.sv
bench/tb_request_circuit_breaker.sv
